/* hw/rtl/dmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the delta modulation crusher.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Default sizing
  localparam int DMC_CHANNELS    = 2;
  localparam int DMC_SAMPLE_BITS = 16;

  // Field widths
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 16;
  localparam int QUAL_W    = 4;
  localparam int COUNT_W   = 15;
  localparam int LEVEL_W   = 8;

  // Numeric constants
  localparam int LEVEL_MAX = 64;
  localparam int MIX_FULL  = 32768;

  // Reset values of the configuration registers
  localparam int RST_INPUT_GAIN  = 16384;
  localparam int RST_OUTPUT_GAIN = 16384;
  localparam int RST_MIX_AMOUNT  = 32768;
  localparam int RST_QUALITY     = 15;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN  = 3'd0,
    REG_OUTPUT_GAIN = 3'd1,
    REG_MIX_AMOUNT  = 3'd2,
    REG_QUALITY     = 3'd3,
    REG_BYPASS      = 3'd4
  } cfg_reg_e;

  // Operations of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,  // sample * input_gain
    MUL_DRY   = 2'd1,  // sample * (full - mix)
    MUL_WET   = 2'd2,  // level * output_gain
    MUL_MIX   = 2'd3   // (level * output_gain) * mix
  } mul_op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] input_gain;
    logic [GAIN_W-1:0] output_gain;
    logic [GAIN_W-1:0] mix_amount;
    logic [QUAL_W-1:0] quality;
    logic              bypass;
  } dmc_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // capture input transaction and channel state
    logic    mul_en;      // run the multiplier this cycle
    mul_op_e mul_op;
    logic    update;      // step the level and hold counter
    logic    out_load;    // write the output register
    logic    out_bypass;  // output register takes the raw sample
  } dmc_cmd_t;

endpackage

/* hw/rtl/dmc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module dmc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dmc_pkg::GAIN_W-1:0]       cfg_data_i,
  output dmc_pkg::dmc_cfg_t                cfg_o
);

  dmc_pkg::dmc_cfg_t cfg_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gain  <= dmc_pkg::GAIN_W'(dmc_pkg::RST_INPUT_GAIN);
      cfg_q.output_gain <= dmc_pkg::GAIN_W'(dmc_pkg::RST_OUTPUT_GAIN);
      cfg_q.mix_amount  <= dmc_pkg::GAIN_W'(dmc_pkg::RST_MIX_AMOUNT);
      cfg_q.quality     <= dmc_pkg::QUAL_W'(dmc_pkg::RST_QUALITY);
      cfg_q.bypass      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dmc_pkg::REG_INPUT_GAIN:  cfg_q.input_gain  <= cfg_data_i;
        dmc_pkg::REG_OUTPUT_GAIN: cfg_q.output_gain <= cfg_data_i;
        dmc_pkg::REG_MIX_AMOUNT:  cfg_q.mix_amount  <= cfg_data_i;
        dmc_pkg::REG_QUALITY:     cfg_q.quality     <= cfg_data_i[dmc_pkg::QUAL_W-1:0];
        dmc_pkg::REG_BYPASS:      cfg_q.bypass      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/dmc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: walks one sample through the four multiplies (skipped in bypass) and the output.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic               bypass_i,
  output dmc_pkg::dmc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DRY,
    ST_WET,
    ST_MIX,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Datapath commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.out_bypass = bypass_i;
    cmd_o.mul_op     = dmc_pkg::MUL_SCALE;
    case (state_q)
      ST_SCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = dmc_pkg::MUL_SCALE;
      end
      ST_DRY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = dmc_pkg::MUL_DRY;
        cmd_o.update = 1'b1;
      end
      ST_WET: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = dmc_pkg::MUL_WET;
      end
      ST_MIX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = dmc_pkg::MUL_MIX;
      end
      ST_OUT: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // New result loaded, or the held one taken
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= bypass_i ? ST_OUT : ST_SCALE;
          end
        end
        ST_SCALE: state_q <= ST_DRY;
        ST_DRY:   state_q <= ST_WET;
        ST_WET:   state_q <= ST_MIX;
        ST_MIX:   state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/dmc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_dpath
// Datapath: per-channel level and hold counter, one shared multiplier,
// level stepping, wet/dry sum with rounding and saturation.
// ----------------------------------------------------------------------------
module dmc_dpath #(
  parameter int CHANNELS    = dmc_pkg::DMC_CHANNELS,
  parameter int SAMPLE_BITS = dmc_pkg::DMC_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmc_pkg::dmc_cmd_t             cmd_i,
  input  dmc_pkg::dmc_cfg_t             cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          channel_i,
  input  logic                          block_start_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW    = dmc_pkg::LEVEL_W;
  localparam int WET_W = dmc_pkg::LEVEL_W + dmc_pkg::GAIN_W;
  localparam int MA_W  = (SAMPLE_BITS > WET_W) ? SAMPLE_BITS : WET_W;
  localparam int MB_W  = dmc_pkg::GAIN_W + 2;
  localparam int PW    = MA_W + MB_W;
  localparam int DW    = SAMPLE_BITS + 18;
  localparam int AW    = SAMPLE_BITS + 40;
  localparam int RW    = AW - 35;

  localparam logic signed [DW-1:0] DZ_POS  = DW'(1) <<< (SAMPLE_BITS + 6);
  localparam logic signed [DW-1:0] DZ_NEG  = -DZ_POS;
  localparam logic signed [RW-1:0] RES_MAX = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] RES_MIN = -RES_MAX - RW'(1);
  localparam logic signed [LW-1:0] LVL_MAX = LW'(dmc_pkg::LEVEL_MAX);
  localparam logic signed [LW-1:0] LVL_MIN = -LVL_MAX;

  // Channel state
  logic signed [LW-1:0]                 level_q [CHANNELS];
  logic        [dmc_pkg::COUNT_W-1:0]   hold_q  [CHANNELS];

  // Working registers for the transaction in flight
  logic signed [SAMPLE_BITS-1:0]        smp_q;
  logic        [CW-1:0]                 ch_q;
  logic signed [LW-1:0]                 lvl_q;
  logic        [dmc_pkg::COUNT_W-1:0]   hc_q;
  logic signed [PW-1:0]                 p_q;
  logic signed [PW-1:0]                 a_q;
  logic signed [PW-1:0]                 b_q;
  logic signed [SAMPLE_BITS-1:0]        out_q;

  logic        [CW-1:0]                 ch_in;
  logic        [dmc_pkg::GAIN_W-1:0]    mix_eff;
  logic        [dmc_pkg::GAIN_W-1:0]    dry_f;
  logic signed [MA_W-1:0]               mul_a;
  logic signed [MB_W-1:0]               mul_b;
  logic signed [PW-1:0]                 prod;
  logic signed [DW-1:0]                 delta;
  logic                                 go_up;
  logic                                 big;
  logic signed [LW-1:0]                 lvl_step;
  logic signed [LW-1:0]                 lvl_new;
  logic        [dmc_pkg::COUNT_W-1:0]   hc_mask;
  logic        [dmc_pkg::COUNT_W-1:0]   hc_next;
  logic signed [AW-1:0]                 acc;
  logic signed [RW-1:0]                 res;
  logic signed [SAMPLE_BITS-1:0]        res_sat;

  // Channel index wraps to the channel count
  assign ch_in = (CHANNELS > 1) ? CW'(channel_i) : CW'(0);

  // Mix above full acts as full
  assign mix_eff = (cfg_i.mix_amount > dmc_pkg::GAIN_W'(dmc_pkg::MIX_FULL)) ?
                   dmc_pkg::GAIN_W'(dmc_pkg::MIX_FULL) : cfg_i.mix_amount;
  assign dry_f   = dmc_pkg::GAIN_W'(dmc_pkg::MIX_FULL) - mix_eff;

  // Shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_op)
      dmc_pkg::MUL_SCALE: begin
        mul_a = MA_W'(smp_q);
        mul_b = MB_W'(cfg_i.input_gain);
      end
      dmc_pkg::MUL_DRY: begin
        mul_a = MA_W'(smp_q);
        mul_b = MB_W'(dry_f);
      end
      dmc_pkg::MUL_WET: begin
        mul_a = MA_W'(lvl_q);
        mul_b = MB_W'(cfg_i.output_gain);
      end
      dmc_pkg::MUL_MIX: begin
        mul_a = p_q[MA_W-1:0];
        mul_b = MB_W'(mix_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Level step: compare scaled sample against level with half-step dead zone
  assign delta    = p_q[DW-1:0] - (DW'(lvl_q) <<< (SAMPLE_BITS + 7));
  assign go_up    = !delta[DW-1];
  assign big      = go_up ? (delta >= DZ_POS) : (delta <= DZ_NEG);
  assign lvl_step = go_up ? (lvl_q + LW'(1)) : (lvl_q - LW'(1));

  always_comb begin
    lvl_new = lvl_q;
    if ((hc_q == '0) && big) begin
      if (lvl_step > LVL_MAX) begin
        lvl_new = LVL_MAX;
      end else if (lvl_step < LVL_MIN) begin
        lvl_new = LVL_MIN;
      end else begin
        lvl_new = lvl_step;
      end
    end
  end

  // Hold counter wraps at 2^(15 - quality)
  assign hc_mask = {dmc_pkg::COUNT_W{1'b1}} >> cfg_i.quality;
  assign hc_next = (hc_q + dmc_pkg::COUNT_W'(1)) & hc_mask;

  // Wet/dry sum, round half up, saturate
  assign acc = (AW'(a_q) <<< 20) + (AW'(b_q) <<< (SAMPLE_BITS - 1)) + (AW'(1) <<< 34);
  assign res = acc[AW-1:35];

  always_comb begin
    if (res > RES_MAX) begin
      res_sat = RES_MAX[SAMPLE_BITS-1:0];
    end else if (res < RES_MIN) begin
      res_sat = RES_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_sat = res[SAMPLE_BITS-1:0];
    end
  end

  // Channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= '0;
        hold_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      level_q[ch_q] <= lvl_new;
      hold_q[ch_q]  <= hc_next;
    end
  end

  // Working registers and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= sample_in_i;
      ch_q  <= ch_in;
      lvl_q <= block_start_i ? '0 : level_q[ch_in];
      hc_q  <= block_start_i ? '0 : hold_q[ch_in];
    end
    if (cmd_i.update) begin
      lvl_q <= lvl_new;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        dmc_pkg::MUL_SCALE: p_q <= prod;
        dmc_pkg::MUL_DRY:   a_q <= prod;
        dmc_pkg::MUL_WET:   p_q <= prod;
        dmc_pkg::MUL_MIX:   b_q <= prod;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_bypass ? smp_q : res_sat;
    end
  end

  assign sample_out_o = out_q;

endmodule

/* hw/rtl/delta_modulation_crusher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_modulation_crusher_top
// Delta modulation bit crusher with per-channel step level and hold counter.
// ----------------------------------------------------------------------------
// One sample is processed at a time. The input stays stalled from acceptance
// until the result is written to the output register, so a new sample is
// taken only after the previous one has reached it, later while a finished
// result waits on a stalled output register: the shared signed multiplier is
// used four times in sequence (input gain, dry share, output gain, wet share),
// then the wet/dry sum is rounded and saturated; bypass skips the multiplies.
// The output register lets the next sample be taken while the previous result
// is still stalled. Configuration writes must only be issued while no sample
// is in flight.
module delta_modulation_crusher_top #(
  parameter int CHANNELS    = dmc_pkg::DMC_CHANNELS,
  parameter int SAMPLE_BITS = dmc_pkg::DMC_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dmc_pkg::GAIN_W-1:0]    cfg_data_i,
  // Input samples
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          channel_i,
  input  logic                          block_start_i,
  // Output samples
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  dmc_pkg::dmc_cfg_t cfg;
  dmc_pkg::dmc_cmd_t cmd;

  dmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bypass_i    (cfg.bypass),
    .cmd_o       (cmd)
  );

  dmc_dpath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .sample_in_i   (sample_in_i),
    .channel_i     (channel_i),
    .block_start_i (block_start_i),
    .sample_out_o  (sample_out_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delta modulation crusher. A clocked driver sends
// queued stereo samples, a clocked monitor compares every output transaction
// with a bit-exact prediction of level tracking, hold counting and wet/dry
// mixing. Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import dmc_pkg::*;

  localparam int SBITS = DMC_SAMPLE_BITS;

  // Fixed point units of the scaled sample: one level step and the dead zone
  localparam longint STEP_UNIT = longint'(1) << (SBITS + 7);
  localparam longint DEAD_ZONE = longint'(1) << (SBITS + 6);
  localparam longint OUT_MAX   = (longint'(1) << (SBITS - 1)) - 1;
  localparam longint OUT_MIN   = -(longint'(1) << (SBITS - 1));

  // Long receiver hold-off
  localparam int PRESSURE_AT  = 400;
  localparam int PRESSURE_LEN = 150;
  localparam int IDLE_PCT     = 22;

  typedef struct {
    logic signed [SBITS-1:0] sample;
    logic                    channel;
    logic                    block_start;
  } crush_item_t;

  // Clock, reset and block inputs
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [GAIN_W-1:0]       cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic signed [SBITS-1:0] sample_in_i   = '0;
  logic                    channel_i     = 1'b0;
  logic                    block_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic signed [SBITS-1:0] sample_out_o;

  // Stimulus and expectations
  crush_item_t             pending_items[$];
  logic signed [SBITS-1:0] expected_samples[$];
  int                      errors        = 0;
  int                      results_seen  = 0;
  int                      hold_left     = 0;
  bit                      pressure_done = 1'b0;
  bit                      steady_run    = 1'b0;

  // Predicted configuration and per-channel state
  logic [GAIN_W-1:0] cfg_in_gain  = GAIN_W'(RST_INPUT_GAIN);
  logic [GAIN_W-1:0] cfg_out_gain = GAIN_W'(RST_OUTPUT_GAIN);
  logic [GAIN_W-1:0] cfg_mix      = GAIN_W'(RST_MIX_AMOUNT);
  logic [QUAL_W-1:0] cfg_quality  = QUAL_W'(RST_QUALITY);
  logic              cfg_bypass   = 1'b0;
  int                crush_level[DMC_CHANNELS];
  int unsigned       crush_hold[DMC_CHANNELS];

  delta_modulation_crusher_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .channel_i     (channel_i),
    .block_start_i (block_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Crusher prediction: updates level and hold counter, returns the output
  function automatic logic signed [SBITS-1:0] crush_predict(
    input logic signed [SBITS-1:0] smp, input logic ch, input logic blk);
    longint s, delta, mag, wet_share, acc, res;
    int     lvl;
    int unsigned span;
    s = smp;
    if (cfg_bypass) return smp;
    if (blk) begin
      crush_level[ch] = 0;
      crush_hold[ch]  = 0;
    end
    // Level moves one step toward the scaled input outside the dead zone
    if (crush_hold[ch] == 0) begin
      delta = s * longint'(cfg_in_gain) - longint'(crush_level[ch]) * STEP_UNIT;
      mag   = (delta < 0) ? -delta : delta;
      if (mag >= DEAD_ZONE) begin
        lvl = crush_level[ch] + ((delta >= 0) ? 1 : -1);
        if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        if (lvl < -LEVEL_MAX) lvl = -LEVEL_MAX;
        crush_level[ch] = lvl;
      end
    end
    span = 32'd1 << (COUNT_W - int'(cfg_quality));
    crush_hold[ch] = (crush_hold[ch] + 1) & (span - 1);
    // Exact wet/dry mix, round half up, saturate
    wet_share = (longint'(cfg_mix) > MIX_FULL) ? longint'(MIX_FULL) : longint'(cfg_mix);
    acc = s * (longint'(1) << 20) * (longint'(MIX_FULL) - wet_share)
        + longint'(crush_level[ch]) * longint'(cfg_out_gain)
          * (longint'(1) << (SBITS - 1)) * wet_share;
    res = (acc + (longint'(1) << 34)) >>> 35;
    if (res > OUT_MAX) res = OUT_MAX;
    if (res < OUT_MIN) res = OUT_MIN;
    return res[SBITS-1:0];
  endfunction

  // Sample driver: predicts on acceptance, then offers the next queued item
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    crush_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_samples = {expected_samples,
                            crush_predict(sample_in_i, channel_i, block_start_i)};
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          in_valid_i    <= 1'b1;
          sample_in_i   <= nxt.sample;
          channel_i     <= nxt.channel;
          block_start_i <= nxt.block_start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : sample_monitor
    logic signed [SBITS-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t unexpected output transaction: expected none actual %0d",
                   $time, sample_out_o);
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_o !== want) begin
            errors++;
            $display("%0t sample_out mismatch: expected %0d actual %0d",
                     $time, want, sample_out_o);
          end
        end
        results_seen++;
      end
      if (!pressure_done && results_seen >= PRESSURE_AT && pending_items.size() > 16) begin
        hold_left     = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady_run && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic add_item(input int value, input logic ch, input logic blk);
    crush_item_t it;
    it.sample      = SBITS'(value);
    it.channel     = ch;
    it.block_start = blk;
    pending_items = {pending_items, it};
  endtask

  // Wait until every sample is out and the pipeline has settled
  task automatic drain();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_INPUT_GAIN:  cfg_in_gain  = data;
      REG_OUTPUT_GAIN: cfg_out_gain = data;
      REG_MIX_AMOUNT:  cfg_mix      = data;
      REG_QUALITY:     cfg_quality  = data[QUAL_W-1:0];
      REG_BYPASS:      cfg_bypass   = data[0];
      default: ;
    endcase
  endtask

  // Full register set plus one write to an unmapped index
  task automatic set_config(input logic [GAIN_W-1:0] in_gain, input logic [GAIN_W-1:0] out_gain,
                            input logic [GAIN_W-1:0] mix, input logic [GAIN_W-1:0] qual_word,
                            input logic [GAIN_W-1:0] bypass_word);
    drain();
    write_reg(REG_INPUT_GAIN, in_gain);
    write_reg(REG_OUTPUT_GAIN, out_gain);
    write_reg(REG_MIX_AMOUNT, mix);
    write_reg(REG_QUALITY, qual_word);
    write_reg(REG_BYPASS, bypass_word);
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_BYPASS + 1)),
              GAIN_W'($urandom));
    @(negedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return GAIN_W'(RST_INPUT_GAIN);
      3: return GAIN_W'(MIX_FULL);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // One stereo buffer: block_start on the first frame of each channel
  task automatic queue_buffer();
    int kind, frames, per, k, ch, v;
    int walk[2];
    kind   = $urandom_range(3);
    frames = (kind == 0) ? $urandom_range(80, 40) : $urandom_range(24, 4);
    per    = ($urandom_range(2) == 0) ? 1000 : $urandom_range(8, 1);
    walk[0] = $urandom_range(65535) - 32768;
    walk[1] = $urandom_range(65535) - 32768;
    for (k = 0; k < frames; k++) begin
      for (ch = 0; ch < DMC_CHANNELS; ch++) begin
        case (kind)
          0: v = (((k / per) % 2) ^ ch) ? 32767 : -32768;
          1: begin
            walk[ch] += $urandom_range(4095) - 2048;
            if (walk[ch] > 32767) walk[ch] = 32767;
            if (walk[ch] < -32768) walk[ch] = -32768;
            v = walk[ch];
          end
          2: v = $urandom_range(65535) - 32768;
          default: v = $urandom_range(1023) - 512;  // around the dead zone
        endcase
        add_item(v, ch[0], k == 0);
      end
    end
  endtask

  // Mostly well-formed buffers, some raw noise
  task automatic queue_phase(input int count);
    while (pending_items.size() < count) begin
      if ($urandom_range(4) == 0)
        add_item($urandom_range(65535) - 32768, 1'($urandom_range(1)),
                 $urandom_range(3) == 0);
      else
        queue_buffer();
    end
  endtask

  initial begin : stimulus
    int               ph;
    logic [QUAL_W-1:0] q;
    logic             byp;
    @(posedge clk_i);
    @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: dead zone edges, zero difference, full scale
    add_item(256, 1'b0, 1'b1);
    add_item(255, 1'b1, 1'b1);
    add_item(0, 1'b0, 1'b1);
    add_item(-256, 1'b1, 1'b1);
    add_item(32767, 1'b0, 1'b0);
    add_item(-32768, 1'b1, 1'b0);
    add_item(-1, 1'b0, 1'b1);
    add_item(1, 1'b1, 1'b0);

    // Maximum gains, fully wet mix, level steps on every sample
    set_config('1, '1, GAIN_W'(MIX_FULL), GAIN_W'(15), '0);
    add_item(32767, 1'b0, 1'b1);
    add_item(-32768, 1'b1, 1'b1);
    add_item(32767, 1'b0, 1'b0);
    add_item(0, 1'b1, 1'b0);

    // Mix above full, hold interval of four
    set_config(GAIN_W'(32768), GAIN_W'(16384), GAIN_W'(40000), GAIN_W'(13), '0);
    add_item(16384, 1'b0, 1'b1);
    add_item(16384, 1'b0, 1'b0);
    add_item(-16384, 1'b0, 1'b0);
    add_item(128, 1'b1, 1'b1);

    // Bypass, with upper data bits set; block_start ignored
    set_config(GAIN_W'(16384), GAIN_W'(16384), GAIN_W'(16384), '1, '1);
    add_item(32767, 1'b0, 1'b1);
    add_item(-32768, 1'b1, 1'b1);

    // Zero gains, fully dry, longest hold interval; only low bits kept
    set_config('0, '0, '0, 16'hFFF0, 16'hFFFE);
    add_item(1234, 1'b0, 1'b1);
    add_item(-32768, 1'b1, 1'b0);
    add_item(32767, 1'b0, 1'b0);

    // Random phases
    for (ph = 0; ph < 10; ph++) begin
      q   = ($urandom_range(3) == 0) ? QUAL_W'($urandom) : QUAL_W'($urandom_range(15, 12));
      byp = (ph == 5) || ($urandom_range(7) == 0);
      set_config(pick_gain(), pick_gain(), pick_gain(), {12'($urandom), q},
                 {15'($urandom), byp});
      steady_run = (ph == 2);
      queue_phase(byp ? 40 : $urandom_range(100, 60));
    end

    drain();
    steady_run = 1'b0;
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_cfg.sv
hw/rtl/dmc_ctrl.sv
hw/rtl/dmc_dpath.sv
hw/rtl/delta_modulation_crusher_top.sv
tb/testbench.sv
